// ===== hdl/ile_pkg.sv =====
package ile_pkg;

	localparam logic [2:0] OP_INSERT  = 3'd0;
	localparam logic [2:0] OP_APPEND  = 3'd1;
	localparam logic [2:0] OP_REMOVE  = 3'd2;
	localparam logic [2:0] OP_REMLAST = 3'd3;
	localparam logic [2:0] OP_FIND    = 3'd4;
	localparam logic [2:0] OP_READ    = 3'd5;
	localparam logic [2:0] OP_MIRROR  = 3'd6;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_RANGE    = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [1:0] IDX_COUNT = 2'd0;
	localparam logic [1:0] IDX_TGT   = 2'd1;
	localparam logic [1:0] IDX_ZERO  = 2'd2;

	localparam logic [2:0] RA_IDX  = 3'd0;
	localparam logic [2:0] RA_PREV = 3'd1;
	localparam logic [2:0] RA_NEXT = 3'd2;
	localparam logic [2:0] RA_MIR  = 3'd3;
	localparam logic [2:0] RA_TGT  = 3'd4;

	typedef struct packed {
		logic [2:0]        op;
		logic [4:0]        position;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [3:0]         found_index;
		logic signed [31:0] read_value;
		logic signed [31:0] diff_value;
		logic [4:0]         length;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       idx_set;
		logic [1:0] idx_sel;
		logic       idx_inc;
		logic       idx_dec;
		logic       rd;
		logic [2:0] ra_sel;
		logic       wr;
		logic       wd_val;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       st_set;
		logic [2:0] st_code;
		logic       save_a;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic [2:0] chk;
		logic [2:0] op;
		logic       idx_gt_tgt;
		logic       next_lt_cnt;
		logic       idx_lt_cnt;
		logic       match;
	} sts_t;

endpackage

// ===== hdl/indexed_list_engine_core.sv =====
// Ordered list of up to CAPACITY signed 32-bit values in a single-port memory with a
// registered read. A request is transferred when start is high and busy is low; busy
// then stays high until the result is shown, and done marks the result for exactly
// one cycle, so the receiver must take it then. Every entry that is moved is read and
// then written back on the memory port, and a find reads and compares the entries in
// turn from index 0; an error, an unknown op or a read goes straight to the result, and
// a mirror read fetches both of its entries first. A new request may be transferred
// in the cycle that done is high.
module indexed_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ile_pkg::req_t req,
	output logic          done,
	output ile_pkg::rsp_t rsp
);
	import ile_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ile_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	ile_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

// ===== hdl/ile_dpath.sv =====
module ile_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ile_pkg::req_t req,
	input  ile_pkg::cmd_t cmd,
	output ile_pkg::sts_t sts,
	output logic          done,
	output ile_pkg::rsp_t rsp
);
	import ile_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = (CW > 5) ? CW : 5;

	logic [31:0]   mem [CAPACITY];
	logic [2:0]    op_q;
	logic [4:0]    pos_q;
	logic [31:0]   val_q;
	logic [2:0]    st_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rdata_q;
	logic [31:0]   a_q;
	logic          done_q;
	rsp_t          rsp_q;
	rsp_t          rsp_d;

	logic [PW-1:0] pos_x;
	logic [PW-1:0] cnt_x;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] tgt;
	logic [CW-1:0] mir;
	logic [CW-1:0] idx_p1;
	logic [CW-1:0] idx_m1;
	logic [CW-1:0] raddr;
	logic [31:0]   wdata;
	logic          full;
	logic          empty;
	logic          ok;
	logic [2:0]    chk;

	assign pos_x  = PW'(pos_q);
	assign cnt_x  = PW'(cnt_q);
	assign pos_c  = CW'(pos_q);
	assign cnt_m1 = cnt_q - CW'(1);
	assign mir    = cnt_m1 - pos_c;
	assign idx_p1 = idx_q + CW'(1);
	assign idx_m1 = idx_q - CW'(1);
	assign full   = (cnt_q == CW'(CAPACITY));
	assign empty  = (cnt_q == '0);

	always_comb begin
		priority if (op_q == OP_APPEND) begin
			tgt = cnt_q;
		end else if (op_q == OP_REMLAST) begin
			tgt = cnt_m1;
		end else begin
			tgt = pos_c;
		end
	end

	always_comb begin
		chk = ST_OK;
		unique case (op_q)
			OP_INSERT: begin
				if (pos_x > cnt_x) chk = ST_RANGE;
				else if (full) chk = ST_FULL;
			end
			OP_APPEND: begin
				if (full) chk = ST_FULL;
			end
			OP_REMOVE: begin
				if (empty) chk = ST_EMPTY;
				else if (pos_x >= cnt_x) chk = ST_RANGE;
			end
			OP_REMLAST: begin
				if (empty) chk = ST_EMPTY;
			end
			OP_READ, OP_MIRROR: begin
				if (pos_x >= cnt_x) chk = ST_RANGE;
			end
			default: chk = ST_OK;
		endcase
	end

	always_comb begin
		unique case (cmd.ra_sel)
			RA_IDX:  raddr = idx_q;
			RA_PREV: raddr = idx_m1;
			RA_NEXT: raddr = idx_p1;
			RA_MIR:  raddr = mir;
			RA_TGT:  raddr = tgt;
			default: raddr = idx_q;
		endcase
	end

	assign wdata = cmd.wd_val ? val_q : rdata_q;

	assign sts.chk         = chk;
	assign sts.op          = op_q;
	assign sts.idx_gt_tgt  = (idx_q > tgt);
	assign sts.next_lt_cnt = (idx_p1 < cnt_q);
	assign sts.idx_lt_cnt  = (idx_q < cnt_q);
	assign sts.match       = (rdata_q == val_q);

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[idx_q[AW-1:0]] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[raddr[AW-1:0]];
		end
		if (cmd.save_a) begin
			a_q <= rdata_q;
		end
		if (cmd.load) begin
			op_q  <= req.op;
			pos_q <= req.position;
			val_q <= req.item_value;
		end
		if (cmd.emit) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			st_q   <= ST_OK;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.load) begin
				st_q <= ST_OK;
			end else if (cmd.st_set) begin
				st_q <= cmd.st_code;
			end
			if (cmd.idx_set) begin
				unique case (cmd.idx_sel)
					IDX_COUNT: idx_q <= cnt_q;
					IDX_TGT:   idx_q <= tgt;
					IDX_ZERO:  idx_q <= '0;
					default:   idx_q <= '0;
				endcase
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end
		end
	end

	assign ok = (st_q == ST_OK);

	always_comb begin
		rsp_d.status      = st_q;
		rsp_d.found_index = (ok && op_q == OP_FIND) ? 4'(idx_q) : 4'd0;
		rsp_d.read_value  = (ok && (op_q == OP_READ || op_q == OP_MIRROR)) ? rdata_q : 32'd0;
		rsp_d.diff_value  = (ok && op_q == OP_MIRROR) ? (a_q - rdata_q) : 32'd0;
		rsp_d.length      = 5'(cnt_q);
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== hdl/ile_ctrl.sv =====
module ile_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ile_pkg::sts_t sts,
	output ile_pkg::cmd_t cmd,
	output logic          busy
);
	import ile_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHECK    = 4'd1;
	localparam logic [3:0] S_UP       = 4'd2;
	localparam logic [3:0] S_UP_WR    = 4'd3;
	localparam logic [3:0] S_DN       = 4'd4;
	localparam logic [3:0] S_DN_WR    = 4'd5;
	localparam logic [3:0] S_FIND     = 4'd6;
	localparam logic [3:0] S_FIND_CMP = 4'd7;
	localparam logic [3:0] S_MIR      = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.chk != ST_OK) begin
					cmd.st_set  = 1'b1;
					cmd.st_code = sts.chk;
					state_d     = S_DONE;
				end else begin
					unique case (sts.op)
						OP_INSERT, OP_APPEND: begin
							cmd.idx_set = 1'b1;
							cmd.idx_sel = IDX_COUNT;
							state_d     = S_UP;
						end
						OP_REMOVE, OP_REMLAST: begin
							cmd.idx_set = 1'b1;
							cmd.idx_sel = IDX_TGT;
							state_d     = S_DN;
						end
						OP_FIND: begin
							cmd.idx_set = 1'b1;
							cmd.idx_sel = IDX_ZERO;
							state_d     = S_FIND;
						end
						OP_READ: begin
							cmd.rd     = 1'b1;
							cmd.ra_sel = RA_TGT;
							state_d    = S_DONE;
						end
						OP_MIRROR: begin
							cmd.rd     = 1'b1;
							cmd.ra_sel = RA_TGT;
							state_d    = S_MIR;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_UP: begin
				if (sts.idx_gt_tgt) begin
					cmd.rd     = 1'b1;
					cmd.ra_sel = RA_PREV;
					state_d    = S_UP_WR;
				end else begin
					cmd.wr      = 1'b1;
					cmd.wd_val  = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_UP_WR: begin
				cmd.wr      = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d     = S_UP;
			end
			S_DN: begin
				if (sts.next_lt_cnt) begin
					cmd.rd     = 1'b1;
					cmd.ra_sel = RA_NEXT;
					state_d    = S_DN_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DN_WR: begin
				cmd.wr      = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_DN;
			end
			S_FIND: begin
				if (sts.idx_lt_cnt) begin
					cmd.rd     = 1'b1;
					cmd.ra_sel = RA_IDX;
					state_d    = S_FIND_CMP;
				end else begin
					cmd.st_set  = 1'b1;
					cmd.st_code = ST_NOTFOUND;
					state_d     = S_DONE;
				end
			end
			S_FIND_CMP: begin
				if (sts.match) begin
					state_d = S_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_FIND;
				end
			end
			S_MIR: begin
				cmd.save_a = 1'b1;
				cmd.rd     = 1'b1;
				cmd.ra_sel = RA_MIR;
				state_d    = S_DONE;
			end
			S_DONE: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/ile_checker.sv =====
module ile_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input ile_pkg::req_t req,
	input logic          done,
	input ile_pkg::rsp_t rsp
);
	import ile_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after a transfer");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |->
			(rsp.read_value == 32'sd0 && rsp.diff_value == 32'sd0 &&
			 rsp.found_index == 4'd0))
		else $error("error result carries data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_RANGE ||
			rsp.status == ST_EMPTY || rsp.status == ST_NOTFOUND ||
			rsp.status == ST_FULL))
		else $error("undefined status code");

endmodule

bind indexed_list_engine_core ile_checker u_ile_checker (.*);
